### sv/segi_pkg.sv
// ============================================================================
// segi_pkg
// Types and widths shared by the segment intersection pipeline.
// ============================================================================
package segi_pkg;

    localparam int COORD_W = 16;               // coordinate width, Q8.8
    localparam int DIFF_W  = COORD_W + 1;      // endpoint difference
    localparam int PROD_W  = 2 * COORD_W;      // coordinate product
    localparam int CROS_W  = 2 * COORD_W + 1;  // line constant x1*y2 - y1*x2
    localparam int DET_W   = 2 * COORD_W + 3;  // determinant
    localparam int NUM_W   = 3 * COORD_W + 4;  // numerators, signed
    localparam int MAG_W   = 3 * COORD_W + 4;  // magnitudes in the divider
    localparam int DIV_STEPS = COORD_W;        // one quotient bit per stage

    typedef logic signed [COORD_W-1:0] t_coord;

    typedef struct packed {
        t_coord a_start_x;
        t_coord a_start_y;
        t_coord a_end_x;
        t_coord a_end_y;
        t_coord b_start_x;
        t_coord b_start_y;
        t_coord b_end_x;
        t_coord b_end_y;
    } t_seg_in;

    typedef struct packed {
        logic   hit;
        t_coord cross_x;
        t_coord cross_y;
        logic   y_clipped;
    } t_seg_out;

    // One item on its way through the divider stages.
    typedef struct packed {
        t_coord             xa;
        t_coord             xb;
        t_coord             xc;
        t_coord             xd;
        logic               det_zero;
        logic               neg_x;
        logic               neg_y;
        logic               ovf_x;
        logic               ovf_y;
        logic [MAG_W-1:0]   dsh;
        logic [MAG_W-1:0]   rx;
        logic [MAG_W-1:0]   ry;
        logic [COORD_W-1:0] qx;
        logic [COORD_W-1:0] qy;
    } t_div_item;

endpackage

### sv/segment_intersection.sv
// ============================================================================
// segment_intersection
// Crossing point of two line segments in signed Q8.8, fully pipelined.
// ============================================================================
// Usage:
// Each input item carries the endpoints of two segments. The block forms the
// determinant of the two lines and, when it is nonzero, the crossing point
// with both quotients truncated towards zero. A hit is reported when the
// crossing x lies within both segments' x ranges; the crossing y is clamped
// to the format and flagged when it does not fit.
// Both channels use valid and stall. An item is taken on a rising edge with
// i_valid high and o_stall low; a result leaves with o_valid high and
// i_stall low.
// An item passes through six stages of products and sums, sixteen restoring
// divider stages (one quotient bit each) and the output register.
// Throughput is one item per cycle. When the receiver stalls with a result
// waiting, the whole pipeline holds and o_stall is raised.
// Reset empties the pipeline; no result is valid after it.
// ============================================================================
module segment_intersection import segi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_seg_in  i_item,
    output logic     o_valid,
    input  logic     i_stall,
    output t_seg_out o_item
);

    logic      w_adv;
    logic      w_vld [DIV_STEPS+1];
    t_div_item w_itm [DIV_STEPS+1];
    t_seg_out  w_res;
    logic      r_out_valid;
    t_seg_out  r_out_item;

    assign w_adv   = !(r_out_valid && i_stall);
    assign o_stall = !w_adv;

    segi_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_valid),
        .i_item  (i_item),
        .o_valid (w_vld[0]),
        .o_item  (w_itm[0])
    );

    for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
        segi_div_step u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_valid (w_vld[g]),
            .i_item  (w_itm[g]),
            .o_valid (w_vld[g+1]),
            .o_item  (w_itm[g+1])
        );
    end

    segi_back u_back (
        .i_item (w_itm[DIV_STEPS]),
        .o_item (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_item <= w_res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_item  = r_out_item;

`ifndef SYNTHESIS
    a_miss_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_item.hit) |->
        (o_item.cross_x == '0 && o_item.cross_y == '0 && !o_item.y_clipped))
        else $error("miss result carries nonzero fields");

    a_clip_rail : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_item.y_clipped) |->
        (o_item.hit && (o_item.cross_y == {1'b0, {(COORD_W-1){1'b1}}} ||
                        o_item.cross_y == {1'b1, {(COORD_W-1){1'b0}}})))
        else $error("clipped y is not at a rail");

    a_reset_empty : assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("result valid straight after reset");
`endif

endmodule

### sv/segi_front.sv
// ============================================================================
// segi_front
// Six register stages: differences and products, determinant, numerators,
// magnitudes and the quotient overflow test ahead of the divider.
// ============================================================================
module segi_front import segi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_seg_in   i_item,
    output logic      o_valid,
    output t_div_item o_item
);

    logic [5:0] r_vld;

    // stage 1
    logic signed [DIFF_W-1:0] r1_dx12, r1_dy12, r1_dx34, r1_dy34;
    logic signed [PROD_W-1:0] r1_p1, r1_p2, r1_p3, r1_p4;
    t_coord r1_xa, r1_xb, r1_xc, r1_xd;
    // stage 2
    logic signed [DIFF_W-1:0] r2_dx12, r2_dy12, r2_dx34, r2_dy34;
    logic signed [CROS_W-1:0] r2_c12, r2_c34;
    logic signed [DET_W-1:0]  r2_d1, r2_d2;
    t_coord r2_xa, r2_xb, r2_xc, r2_xd;
    // stage 3
    logic signed [DET_W-1:0]  r3_det;
    logic signed [NUM_W-1:0]  r3_m1, r3_m2, r3_m3, r3_m4;
    t_coord r3_xa, r3_xb, r3_xc, r3_xd;
    // stage 4
    logic signed [DET_W-1:0]  r4_det;
    logic signed [NUM_W-1:0]  r4_nx, r4_ny;
    t_coord r4_xa, r4_xb, r4_xc, r4_xd;
    // stage 5
    logic [MAG_W-1:0] r5_nxm, r5_nym, r5_dm;
    logic r5_negx, r5_negy, r5_detz;
    t_coord r5_xa, r5_xb, r5_xc, r5_xd;
    // stage 6
    t_div_item r6_item;

    logic [MAG_W-1:0] n_dsh;
    assign n_dsh = r5_dm << (COORD_W - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r1_dx12 <= DIFF_W'(i_item.a_start_x) - DIFF_W'(i_item.a_end_x);
            r1_dy12 <= DIFF_W'(i_item.a_start_y) - DIFF_W'(i_item.a_end_y);
            r1_dx34 <= DIFF_W'(i_item.b_start_x) - DIFF_W'(i_item.b_end_x);
            r1_dy34 <= DIFF_W'(i_item.b_start_y) - DIFF_W'(i_item.b_end_y);
            r1_p1   <= PROD_W'(i_item.a_start_x) * PROD_W'(i_item.a_end_y);
            r1_p2   <= PROD_W'(i_item.a_start_y) * PROD_W'(i_item.a_end_x);
            r1_p3   <= PROD_W'(i_item.b_start_x) * PROD_W'(i_item.b_end_y);
            r1_p4   <= PROD_W'(i_item.b_start_y) * PROD_W'(i_item.b_end_x);
            r1_xa   <= i_item.a_start_x;
            r1_xb   <= i_item.a_end_x;
            r1_xc   <= i_item.b_start_x;
            r1_xd   <= i_item.b_end_x;

            r2_dx12 <= r1_dx12;
            r2_dy12 <= r1_dy12;
            r2_dx34 <= r1_dx34;
            r2_dy34 <= r1_dy34;
            r2_c12  <= CROS_W'(r1_p1) - CROS_W'(r1_p2);
            r2_c34  <= CROS_W'(r1_p3) - CROS_W'(r1_p4);
            r2_d1   <= DET_W'(r1_dx12) * DET_W'(r1_dy34);
            r2_d2   <= DET_W'(r1_dy12) * DET_W'(r1_dx34);
            {r2_xa, r2_xb, r2_xc, r2_xd} <= {r1_xa, r1_xb, r1_xc, r1_xd};

            r3_det <= r2_d1 - r2_d2;
            r3_m1  <= NUM_W'(r2_dx34) * NUM_W'(r2_c12);
            r3_m2  <= NUM_W'(r2_dx12) * NUM_W'(r2_c34);
            r3_m3  <= NUM_W'(r2_dy34) * NUM_W'(r2_c12);
            r3_m4  <= NUM_W'(r2_dy12) * NUM_W'(r2_c34);
            {r3_xa, r3_xb, r3_xc, r3_xd} <= {r2_xa, r2_xb, r2_xc, r2_xd};

            r4_det <= r3_det;
            r4_nx  <= r3_m1 - r3_m2;
            r4_ny  <= r3_m3 - r3_m4;
            {r4_xa, r4_xb, r4_xc, r4_xd} <= {r3_xa, r3_xb, r3_xc, r3_xd};

            r5_nxm  <= r4_nx[NUM_W-1] ? MAG_W'(-r4_nx) : MAG_W'(r4_nx);
            r5_nym  <= r4_ny[NUM_W-1] ? MAG_W'(-r4_ny) : MAG_W'(r4_ny);
            r5_dm   <= r4_det[DET_W-1] ? MAG_W'(-r4_det) : MAG_W'(r4_det);
            r5_negx <= r4_nx[NUM_W-1] ^ r4_det[DET_W-1];
            r5_negy <= r4_ny[NUM_W-1] ^ r4_det[DET_W-1];
            r5_detz <= (r4_det == '0);
            {r5_xa, r5_xb, r5_xc, r5_xd} <= {r4_xa, r4_xb, r4_xc, r4_xd};

            // A quotient magnitude of 2^COORD_W or more cannot fit the format.
            r6_item.xa       <= r5_xa;
            r6_item.xb       <= r5_xb;
            r6_item.xc       <= r5_xc;
            r6_item.xd       <= r5_xd;
            r6_item.det_zero <= r5_detz;
            r6_item.neg_x    <= r5_negx;
            r6_item.neg_y    <= r5_negy;
            r6_item.ovf_x    <= {1'b0, r5_nxm} >= {n_dsh, 1'b0};
            r6_item.ovf_y    <= {1'b0, r5_nym} >= {n_dsh, 1'b0};
            r6_item.dsh      <= n_dsh;
            r6_item.rx       <= r5_nxm;
            r6_item.ry       <= r5_nym;
            r6_item.qx       <= '0;
            r6_item.qy       <= '0;
        end
    end

    assign o_valid = r_vld[5];
    assign o_item  = r6_item;

endmodule

### sv/segi_div_step.sv
// ============================================================================
// segi_div_step
// One restoring division stage: one quotient bit for x and one for y.
// ============================================================================
module segi_div_step import segi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_adv,
    input  logic      i_valid,
    input  t_div_item i_item,
    output logic      o_valid,
    output t_div_item o_item
);

    logic             r_valid;
    t_div_item        r_item;
    t_div_item        n_item;
    logic             n_gex, n_gey;
    logic [MAG_W-1:0] n_remx, n_remy;

    always_comb begin
        n_gex  = i_item.rx >= i_item.dsh;
        n_gey  = i_item.ry >= i_item.dsh;
        n_remx = n_gex ? i_item.rx - i_item.dsh : i_item.rx;
        n_remy = n_gey ? i_item.ry - i_item.dsh : i_item.ry;
        n_item    = i_item;
        n_item.rx = n_remx << 1;
        n_item.ry = n_remy << 1;
        n_item.qx = {i_item.qx[COORD_W-2:0], n_gex};
        n_item.qy = {i_item.qy[COORD_W-2:0], n_gey};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

### sv/segi_back.sv
// ============================================================================
// segi_back
// Signs the quotients, tests the crossing x against both x ranges and
// saturates the crossing y.
// ============================================================================
module segi_back import segi_pkg::*; (
    input  t_div_item i_item,
    output t_seg_out  o_item
);

    localparam logic signed [DIFF_W-1:0] Y_MAX = DIFF_W'((1 << (COORD_W - 1)) - 1);
    localparam logic signed [DIFF_W-1:0] Y_MIN = -DIFF_W'(1 << (COORD_W - 1));

    logic signed [DIFF_W-1:0] n_qx, n_qy;
    logic signed [DIFF_W-1:0] n_lo_a, n_hi_a, n_lo_b, n_hi_b;
    logic                     n_in_a, n_in_b, n_hit;

    always_comb begin
        n_qx = i_item.neg_x ? -$signed({1'b0, i_item.qx}) : $signed({1'b0, i_item.qx});
        n_qy = i_item.neg_y ? -$signed({1'b0, i_item.qy}) : $signed({1'b0, i_item.qy});

        n_lo_a = (i_item.xa < i_item.xb) ? DIFF_W'(i_item.xa) : DIFF_W'(i_item.xb);
        n_hi_a = (i_item.xa < i_item.xb) ? DIFF_W'(i_item.xb) : DIFF_W'(i_item.xa);
        n_lo_b = (i_item.xc < i_item.xd) ? DIFF_W'(i_item.xc) : DIFF_W'(i_item.xd);
        n_hi_b = (i_item.xc < i_item.xd) ? DIFF_W'(i_item.xd) : DIFF_W'(i_item.xc);
        n_in_a = (n_qx >= n_lo_a) && (n_qx <= n_hi_a);
        n_in_b = (n_qx >= n_lo_b) && (n_qx <= n_hi_b);
        n_hit  = !i_item.det_zero && !i_item.ovf_x && n_in_a && n_in_b;

        o_item = '0;
        if (n_hit) begin
            o_item.hit     = 1'b1;
            o_item.cross_x = n_qx[COORD_W-1:0];
            if (i_item.ovf_y) begin
                o_item.y_clipped = 1'b1;
                o_item.cross_y   = i_item.neg_y ? Y_MIN[COORD_W-1:0] : Y_MAX[COORD_W-1:0];
            end else if (n_qy > Y_MAX) begin
                o_item.y_clipped = 1'b1;
                o_item.cross_y   = Y_MAX[COORD_W-1:0];
            end else if (n_qy < Y_MIN) begin
                o_item.y_clipped = 1'b1;
                o_item.cross_y   = Y_MIN[COORD_W-1:0];
            end else begin
                o_item.cross_y   = n_qy[COORD_W-1:0];
            end
        end
    end

endmodule

### test/segment_intersection_chk.sv
`timescale 1ns / 100ps
// ============================================================================
// segment_intersection_chk
// Watches both channels of the segment intersection block, works out the
// crossing for every accepted item and compares it with the results.
// ============================================================================
module segment_intersection_chk import segi_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  logic     i_in_stall,
    input  t_seg_in  i_in_item,
    input  logic     i_out_valid,
    input  logic     i_out_stall,
    input  t_seg_out i_out_item,
    output int       o_errors,
    output int       o_pending,
    output int       o_results,
    output int       o_hits,
    output int       o_clips
);

    t_seg_out crossing_q[$];

    function automatic logic x_within(longint v, longint p, longint q);
        longint lo;
        longint hi;
        lo = (p < q) ? p : q;
        hi = (p < q) ? q : p;
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic t_seg_out crossing_of(t_seg_in s);
        longint x1, y1, x2, y2, x3, y3, x4, y4;
        longint dx12, dy12, dx34, dy34, c12, c34;
        longint det, nx, ny, xi, yi;
        longint ymax, ymin;
        t_seg_out r;
        r = '0;
        ymax = (64'sd1 <<< (COORD_W - 1)) - 1;
        ymin = -(64'sd1 <<< (COORD_W - 1));
        x1 = s.a_start_x; y1 = s.a_start_y; x2 = s.a_end_x; y2 = s.a_end_y;
        x3 = s.b_start_x; y3 = s.b_start_y; x4 = s.b_end_x; y4 = s.b_end_y;
        dx12 = x1 - x2; dy12 = y1 - y2; dx34 = x3 - x4; dy34 = y3 - y4;
        c12 = x1 * y2 - y1 * x2;
        c34 = x3 * y4 - y3 * x4;
        det = dx12 * dy34 - dy12 * dx34;
        if (det == 0) return r;
        nx = dx34 * c12 - dx12 * c34;
        ny = dy34 * c12 - dy12 * c34;
        // Signed integer division truncates towards zero, as the block does.
        xi = nx / det;
        yi = ny / det;
        if (!x_within(xi, x1, x2) || !x_within(xi, x3, x4)) return r;
        r.hit = 1'b1;
        r.cross_x = t_coord'(xi);
        if (yi > ymax) begin
            r.cross_y = t_coord'(ymax);
            r.y_clipped = 1'b1;
        end else if (yi < ymin) begin
            r.cross_y = t_coord'(ymin);
            r.y_clipped = 1'b1;
        end else begin
            r.cross_y = t_coord'(yi);
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_seg_out want;
        int       bad;
        if (!i_rst_n) begin
            crossing_q.delete();
            o_errors  <= 0;
            o_pending <= 0;
            o_results <= 0;
            o_hits    <= 0;
            o_clips   <= 0;
        end else begin
            bad = 0;
            if (i_in_valid && !i_in_stall) crossing_q.push_back(crossing_of(i_in_item));
            if (i_out_valid && !i_out_stall) begin
                o_results <= o_results + 1;
                if (crossing_q.size() == 0) begin
                    $error("result with no item outstanding");
                    bad = bad + 1;
                end else begin
                    want = crossing_q.pop_front();
                    if (want.hit) o_hits <= o_hits + 1;
                    if (want.y_clipped) o_clips <= o_clips + 1;
                    if (i_out_item.hit !== want.hit) begin
                        $error("hit: expected %0d, got %0d", want.hit, i_out_item.hit);
                        bad = bad + 1;
                    end
                    if (i_out_item.cross_x !== want.cross_x) begin
                        $error("cross_x: expected %0d, got %0d",
                               want.cross_x, i_out_item.cross_x);
                        bad = bad + 1;
                    end
                    if (i_out_item.cross_y !== want.cross_y) begin
                        $error("cross_y: expected %0d, got %0d",
                               want.cross_y, i_out_item.cross_y);
                        bad = bad + 1;
                    end
                    if (i_out_item.y_clipped !== want.y_clipped) begin
                        $error("y_clipped: expected %0d, got %0d",
                               want.y_clipped, i_out_item.y_clipped);
                        bad = bad + 1;
                    end
                end
            end
            o_errors  <= o_errors + bad;
            o_pending <= crossing_q.size();
        end
    end

endmodule

### test/segment_intersection_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// segment_intersection_tb
// Drives directed and random segment pairs with random gaps and stalls.
// ============================================================================
module segment_intersection_tb;
    import segi_pkg::*;

    logic     i_clk = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_stall;
    t_seg_in  i_item = '0;
    logic     o_valid;
    logic     i_stall = 1'b0;
    t_seg_out o_item;

    int err_count, pend_count, res_count, hit_count, clip_count;
    int sent_count = 0;
    int stall_left = 0;
    logic quiet_out = 1'b0;

    always #1 i_clk = ~i_clk;

    segment_intersection uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_item(i_item), .o_valid(o_valid), .i_stall(i_stall), .o_item(o_item)
    );

    segment_intersection_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_valid), .i_in_stall(o_stall), .i_in_item(i_item),
        .i_out_valid(o_valid), .i_out_stall(i_stall), .i_out_item(o_item),
        .o_errors(err_count), .o_pending(pend_count), .o_results(res_count),
        .o_hits(hit_count), .o_clips(clip_count)
    );

    // Mostly short idle spells, now and then a long one.
    function automatic int gap_len();
        int r;
        r = $urandom_range(99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    always @(posedge i_clk) begin
        if (quiet_out) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_stall <= 1'b1;
        end else begin
            stall_left <= gap_len();
            i_stall <= 1'b0;
        end
    end

    task automatic send_pair(input t_seg_in s, input int gap);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= s;
        i_valid <= 1'b1;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sent_count++;
    endtask

    function automatic t_seg_in make_pair(int ax1, int ay1, int ax2, int ay2,
                                          int bx1, int by1, int bx2, int by2);
        t_seg_in s;
        s.a_start_x = t_coord'(ax1); s.a_start_y = t_coord'(ay1);
        s.a_end_x   = t_coord'(ax2); s.a_end_y   = t_coord'(ay2);
        s.b_start_x = t_coord'(bx1); s.b_start_y = t_coord'(by1);
        s.b_end_x   = t_coord'(bx2); s.b_end_y   = t_coord'(by2);
        return s;
    endfunction

    function automatic int rnd_in(int lo, int hi);
        return lo + int'($urandom_range(hi - lo));
    endfunction

    function automatic t_seg_in random_pair(int spell);
        t_seg_in s;
        int k, c, w;
        k = $urandom_range(99);
        if (k < 30) begin
            s = t_seg_in'({$urandom, $urandom, $urandom, $urandom});
        end else if (k < 70) begin
            // Small crossing shapes near a random centre, so hits are common.
            c = rnd_in(-20000, 20000);
            w = (spell == 0) ? 64 : 4000;
            s = make_pair(c + rnd_in(-w, w), c + rnd_in(-w, w), c + rnd_in(-w, w),
                          c + rnd_in(-w, w), c + rnd_in(-w, w), c + rnd_in(-w, w),
                          c + rnd_in(-w, w), c + rnd_in(-w, w));
        end else if (k < 85) begin
            // Steep, narrow segments: the crossing y can run out of format.
            s = make_pair(rnd_in(-3, 3), rnd_in(-32768, 32767), rnd_in(-3, 3),
                          rnd_in(-32768, 32767), rnd_in(-3, 3), rnd_in(-32768, 32767),
                          rnd_in(-3, 3), rnd_in(-32768, 32767));
        end else if (k < 93) begin
            // Parallel or nearly parallel copies of one segment.
            s = t_seg_in'({$urandom, $urandom, $urandom, $urandom});
            s.b_start_x = s.a_start_x + t_coord'(rnd_in(-1, 1));
            s.b_start_y = s.a_start_y + t_coord'(rnd_in(-300, 300));
            s.b_end_x   = s.a_end_x + t_coord'(rnd_in(-1, 1));
            s.b_end_y   = s.a_end_y + t_coord'(rnd_in(-300, 300));
        end else begin
            // A vertical segment against a random one.
            s = t_seg_in'({$urandom, $urandom, $urandom, $urandom});
            s.a_end_x = s.a_start_x;
            s.b_start_x = s.a_start_x - t_coord'(rnd_in(0, 500));
            s.b_end_x = s.a_start_x + t_coord'(rnd_in(0, 500));
        end
        return s;
    endfunction

    initial begin
        t_seg_in plan[$];
        int n;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        plan.push_back('0);
        plan.push_back(make_pair(-32768, -32768, 32767, 32767,
                                 -32768, 32767, 32767, -32768));
        plan.push_back(make_pair(0, 0, 256, 256, 0, 256, 256, 0));
        plan.push_back(make_pair(-256, -256, 256, 256, -256, 256, 256, -256));
        plan.push_back(make_pair(0, 0, 256, 0, 0, 256, 256, 256));
        plan.push_back(make_pair(0, 0, 100, 100, 200, 0, 300, 100));
        plan.push_back(make_pair(0, 0, 100, 100, 300, 0, 400, -100));
        plan.push_back(make_pair(128, -32768, 128, 32767, 0, 0, 256, 256));
        plan.push_back(make_pair(128, -32768, 128, 32767, 0, 32767, 256, -32768));
        plan.push_back(make_pair(128, 0, 128, 100, 128, 50, 128, 500));
        plan.push_back(make_pair(-3, -32768, 3, 32767, -3, -32050, 3, 32767));
        plan.push_back(make_pair(-3, -32768, 3, 32767, -3, -32767, 3, 32700));
        plan.push_back(make_pair(3, 32767, -3, -32768, -3, -32700, 3, 32767));
        plan.push_back(make_pair(0, 0, 3, 1, 0, 1, 3, 0));
        plan.push_back(make_pair(0, 0, -3, 1, 0, 1, -3, 0));
        plan.push_back(make_pair(32767, 32767, 32767, 32767, 0, 0, 1, 1));
        plan.push_back(make_pair(-32768, 0, 32767, 0, 0, -32768, 0, 32767));
        plan.push_back(make_pair(-32768, 0, 32767, 1, 0, -32768, 1, 32767));
        plan.push_back('1);
        foreach (plan[i]) send_pair(plan[i], (i % 3 == 0) ? gap_len() : 0);

        for (n = 0; n < 900; n++) begin
            // Every fourth block of 100 items runs with no gaps on either side.
            quiet_out <= ((n / 100) % 4 == 3);
            send_pair(random_pair(n % 2), ((n / 100) % 4 == 3) ? 0 : gap_len());
        end
        i_valid <= 1'b0;
        quiet_out <= 1'b0;

        @(posedge i_clk);
        while (pend_count != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("Sent %0d segment pairs, checked %0d results.", sent_count, res_count);
        $display("Hits %0d, of which %0d had the crossing y clamped.", hit_count, clip_count);
        if (err_count == 0 && pend_count == 0) begin
            $display("segment_intersection regression: pass");
        end else begin
            $display("segment_intersection regression: fail");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Timed out waiting for the pipeline to drain.");
        $display("segment_intersection regression: fail");
        $finish;
    end

endmodule
